// File: hdl/rcf_pkg.sv
// shared types, widths, register codes and saturation helpers for the
// rf cavity feedback block; no dependencies
package rcf_pkg;

	localparam int DATA_W = 32;
	localparam int SUM_W = 48;
	localparam int PER_W = 16;
	localparam int LEN_W = 7;
	localparam int DEF_MAX_DELAY = 64;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_SET_AMPLITUDE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SET_PHASE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_GAIN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PHASE_GAIN = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TUNER_GAIN = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TUNER_PERIOD = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_TUNER_OFFSET = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_LENGTH = 3'd7;

	// item kinds
	localparam logic KIND_TURN = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] set_amplitude;
		logic signed [DATA_W-1:0] set_phase;
		logic signed [DATA_W-1:0] voltage_gain;
		logic signed [DATA_W-1:0] phase_gain;
		logic signed [DATA_W-1:0] tuner_gain;
		logic [PER_W-1:0]         tuner_period;
		logic signed [DATA_W-1:0] tuner_offset;
		logic [LEN_W-1:0]         delay_length;
	} rcf_cfg_t;

	localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;
	localparam logic signed [63:0] S48_MAX = 64'sh0000_7fff_ffff_ffff;
	localparam logic signed [63:0] S48_MIN = -64'sh0000_8000_0000_0000;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > S32_MAX)
			r = S32_MAX[DATA_W-1:0];
		else if (x < S32_MIN)
			r = S32_MIN[DATA_W-1:0];
		else
			r = x[DATA_W-1:0];
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat48(input logic signed [63:0] x);
		logic signed [SUM_W-1:0] r;
		if (x > S48_MAX)
			r = S48_MAX[SUM_W-1:0];
		else if (x < S48_MIN)
			r = S48_MIN[SUM_W-1:0];
		else
			r = x[SUM_W-1:0];
		return r;
	endfunction

endpackage

// File: hdl/rcf_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module rcf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/rcf_cfg.sv
// apb configuration registers for the cavity feedback loop
// depends on rcf_pkg
module rcf_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [rcf_pkg::APB_AW-1:0] paddr,
	input  logic [rcf_pkg::APB_DW-1:0] pwdata,
	output logic [rcf_pkg::APB_DW-1:0] prdata,
	output logic                     pready,
	output rcf_pkg::rcf_cfg_t        cfg
);
	import rcf_pkg::*;

	rcf_cfg_t cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic wr;

	assign idx = paddr[APB_AW-1:2];
	assign wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{set_amplitude: '0, set_phase: '0, voltage_gain: '0,
				phase_gain: '0, tuner_gain: '0, tuner_period: PER_W'(1),
				tuner_offset: '0, delay_length: LEN_W'(1)};
		end else if (wr) begin
			unique case (idx)
				REG_SET_AMPLITUDE: cfg_q.set_amplitude <= pwdata[DATA_W-1:0];
				REG_SET_PHASE:     cfg_q.set_phase <= pwdata[DATA_W-1:0];
				REG_VOLTAGE_GAIN:  cfg_q.voltage_gain <= pwdata[DATA_W-1:0];
				REG_PHASE_GAIN:    cfg_q.phase_gain <= pwdata[DATA_W-1:0];
				REG_TUNER_GAIN:    cfg_q.tuner_gain <= pwdata[DATA_W-1:0];
				REG_TUNER_PERIOD:  cfg_q.tuner_period <= pwdata[PER_W-1:0];
				REG_TUNER_OFFSET:  cfg_q.tuner_offset <= pwdata[DATA_W-1:0];
				REG_DELAY_LENGTH:  cfg_q.delay_length <= pwdata[LEN_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SET_AMPLITUDE: prdata = cfg_q.set_amplitude;
			REG_SET_PHASE:     prdata = cfg_q.set_phase;
			REG_VOLTAGE_GAIN:  prdata = cfg_q.voltage_gain;
			REG_PHASE_GAIN:    prdata = cfg_q.phase_gain;
			REG_TUNER_GAIN:    prdata = cfg_q.tuner_gain;
			REG_TUNER_PERIOD:  prdata = APB_DW'(cfg_q.tuner_period);
			REG_TUNER_OFFSET:  prdata = cfg_q.tuner_offset;
			REG_DELAY_LENGTH:  prdata = APB_DW'(cfg_q.delay_length);
			default:           prdata = '0;
		endcase
	end

endmodule

// File: hdl/rcf_div.sv
// bit-serial signed divider for the tuner mean: 48-bit sum by 16-bit period,
// quotient truncated toward zero; depends on rcf_pkg
module rcf_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [rcf_pkg::SUM_W-1:0]  dividend,
	input  logic [rcf_pkg::PER_W-1:0]         divisor,
	output logic                              done,
	output logic signed [rcf_pkg::SUM_W-1:0]  quotient
);
	import rcf_pkg::*;

	localparam int CW = $clog2(SUM_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [PER_W:0]   rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [PER_W-1:0] div_q;
	logic [PER_W:0]   shifted;
	logic             ge;

	// magnitude bits enter the remainder msb first
	assign shifted = {rem_q[PER_W-1:0], quo_q[SUM_W-1]};
	assign ge = shifted >= {1'b0, div_q};
	assign done = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? -dividend : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? shifted - {1'b0, div_q} : shifted;
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

endmodule

// File: hdl/rf_cavity_feedback_with_tuner_top.sv
// rf cavity amplitude/phase feedback with slow tuner loop, top level
// depends on rcf_pkg, rcf_cfg, rcf_ram, rcf_div

// One item per turn. A load item (kind 1) presets the generator state; its
// result goes from S_DONE into the output register, and no new item is taken
// before that. A measurement item steps S_SHIFT through the L in-use entries,
// L being the delay length in use, then S_WR0, S_MUL, S_UPD and S_DONE: both
// delay lines share one ram of MAX_DELAY words, and every in-use entry moves
// up one place through its single write port, one entry per cycle. A turn
// that fires a tuner correction also runs the bit-serial 48-bit divide
// (S_DIV), then the gain multiply and update (S_TMUL, S_TUPD). A finished
// result waits in an output register, so the next item may be accepted while
// it is still stalled; a result that finds that register still held waits in
// S_DONE until the register frees. After reset the ram is cleared word by
// word in S_CLEAR, during which item_stall stays high; register writes are
// taken throughout.
module rf_cavity_feedback_with_tuner_top #(
	parameter int MAX_DELAY = rcf_pkg::DEF_MAX_DELAY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rcf_pkg::APB_AW-1:0]          paddr,
	input  logic [rcf_pkg::APB_DW-1:0]          pwdata,
	output logic [rcf_pkg::APB_DW-1:0]          prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                kind,
	input  logic signed [rcf_pkg::DATA_W-1:0]   meas_amplitude,
	input  logic signed [rcf_pkg::DATA_W-1:0]   meas_phase,
	input  logic signed [rcf_pkg::DATA_W-1:0]   meas_detuning,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [rcf_pkg::DATA_W-1:0]   gen_amplitude,
	output logic signed [rcf_pkg::DATA_W-1:0]   gen_phase,
	output logic signed [rcf_pkg::DATA_W-1:0]   gen_detuning,
	output logic                                tuner_applied
);
	import rcf_pkg::*;

	localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int RAM_W = 2 * DATA_W;
	localparam logic [AW-1:0] LAST = AW'(MAX_DELAY - 1);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SHIFT = 4'd2;
	localparam logic [3:0] S_WR0   = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_UPD   = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_TMUL  = 4'd7;
	localparam logic [3:0] S_TUPD  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	rcf_cfg_t cfg;

	logic [3:0]  state_q;
	logic [AW-1:0] ptr_q;
	logic        first_q;

	logic signed [DATA_W-1:0] gen_amp_q, gen_ph_q, gen_psi_q;
	logic signed [DATA_W-1:0] meas_a_q, meas_p_q, meas_d_q;
	logic signed [DATA_W-1:0] old_a_q, old_p_q;
	logic signed [DATA_W-1:0] ea_q, ep_q, corr_q;
	logic signed [63:0]       prod_a_q, prod_p_q, prod_t_q;
	logic [PER_W-1:0]         tcount_q;
	logic signed [SUM_W-1:0]  tsum_q;
	logic [PER_W-1:0]         per_q;
	logic                     fire_q;
	logic                     applied_q;

	logic                     res_valid_q;
	logic signed [DATA_W-1:0] res_amp_q, res_ph_q, res_psi_q;
	logic                     res_applied_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [RAM_W-1:0] ram_wdata, ram_rdata;
	logic [AW-1:0]    oldest_addr;

	logic                    accept;
	logic                    out_free;
	logic                    res_load;
	logic                    tun_on;
	logic [PER_W-1:0]        cnt_nxt;
	logic [PER_W-1:0]        per_eff;
	logic signed [SUM_W-1:0] sum_nxt;
	logic                    div_start;
	logic                    div_done;
	logic signed [SUM_W-1:0] div_quot;

	rcf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// amplitude in the upper half, phase in the lower half
	rcf_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_DELAY),
		.AW    (AW)
	) u_dly (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rcf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tsum_q),
		.divisor  (per_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign item_stall = (state_q != S_IDLE);
	assign accept = item_valid & ~item_stall;
	assign out_free = ~res_valid_q | ~res_stall;
	assign res_load = (state_q == S_DONE) & out_free;
	assign div_start = (state_q == S_UPD) & fire_q;

	assign res_valid = res_valid_q;
	assign gen_amplitude = res_amp_q;
	assign gen_phase = res_ph_q;
	assign gen_detuning = res_psi_q;
	assign tuner_applied = res_applied_q;

	// address of the oldest entry in use; zero length acts as one
	always_comb begin
		if (cfg.delay_length == '0)
			oldest_addr = '0;
		else if (32'(cfg.delay_length) > 32'(MAX_DELAY))
			oldest_addr = LAST;
		else
			oldest_addr = AW'(32'(cfg.delay_length) - 32'd1);
	end

	assign tun_on = cfg.tuner_gain > 32'sd0;
	assign cnt_nxt = tcount_q + PER_W'(1);
	assign per_eff = (cfg.tuner_period == '0) ? PER_W'(1) : cfg.tuner_period;
	assign sum_nxt = sat48(64'(tsum_q) + 64'(meas_d_q) - 64'(gen_psi_q));

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_raddr = oldest_addr;
			end
			S_SHIFT: begin
				// read the next entry down while writing the one just read one place up
				ram_raddr = ptr_q - AW'(1);
				ram_we = ~first_q;
				ram_waddr = ptr_q + AW'(1);
			end
			S_WR0: begin
				ram_we = 1'b1;
				ram_waddr = '0;
				ram_wdata = {meas_a_q, meas_p_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ptr_q <= '0;
			first_q <= 1'b0;
			gen_amp_q <= '0;
			gen_ph_q <= '0;
			gen_psi_q <= '0;
			tcount_q <= '0;
			tsum_q <= '0;
			fire_q <= 1'b0;
			applied_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (ptr_q == LAST) begin
						ptr_q <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						applied_q <= 1'b0;
						if (kind == KIND_LOAD) begin
							gen_amp_q <= meas_amplitude;
							gen_ph_q <= meas_phase;
							gen_psi_q <= meas_detuning;
							state_q <= S_DONE;
						end else begin
							ptr_q <= oldest_addr;
							first_q <= 1'b1;
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					first_q <= 1'b0;
					if (ptr_q == '0)
						state_q <= S_WR0;
					else
						ptr_q <= ptr_q - AW'(1);
				end
				S_WR0: begin
					fire_q <= tun_on & (cnt_nxt >= per_eff);
					if (tun_on) begin
						tcount_q <= cnt_nxt;
						tsum_q <= sum_nxt;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					gen_amp_q <= sat32(64'(gen_amp_q) - (prod_a_q >>> 16));
					gen_ph_q <= sat32(64'(gen_ph_q) - (prod_p_q >>> 16));
					state_q <= fire_q ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_TMUL;
				end
				S_TMUL: begin
					state_q <= S_TUPD;
				end
				S_TUPD: begin
					gen_psi_q <= sat32(64'(gen_psi_q) + (prod_t_q >>> 16));
					tcount_q <= '0;
					tsum_q <= '0;
					applied_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_a_q <= meas_amplitude;
			meas_p_q <= meas_phase;
			meas_d_q <= meas_detuning;
		end
		if (state_q == S_SHIFT && first_q) begin
			old_a_q <= ram_rdata[RAM_W-1:DATA_W];
			old_p_q <= ram_rdata[DATA_W-1:0];
		end
		if (state_q == S_WR0) begin
			ea_q <= sat32(64'(old_a_q) - 64'(cfg.set_amplitude));
			ep_q <= sat32(64'(old_p_q) - 64'(cfg.set_phase));
			per_q <= per_eff;
		end
		if (state_q == S_MUL) begin
			prod_a_q <= 64'(cfg.voltage_gain) * 64'(ea_q);
			prod_p_q <= 64'(cfg.phase_gain) * 64'(ep_q);
		end
		if (state_q == S_DIV && div_done)
			corr_q <= sat32(64'(div_quot) + 64'(cfg.tuner_offset));
		if (state_q == S_TMUL)
			prod_t_q <= 64'(cfg.tuner_gain) * 64'(corr_q);
		if (res_load) begin
			res_amp_q <= gen_amp_q;
			res_ph_q <= gen_ph_q;
			res_psi_q <= gen_psi_q;
			res_applied_q <= applied_q;
		end
	end

endmodule
